// ===== hdl/cwts_pkg.sv =====
// Shared types, constants and record arithmetic of the windowed timing statistics block.
// No dependencies; the top level, the record memory and the testbench import this package.
`default_nettype none
package cwts_pkg;

    localparam int unsigned NWIN = 4;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_TIME   = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic SLOT_ACC  = 1'b0;
    localparam logic SLOT_PREV = 1'b1;

    localparam logic [1:0] WIN_TOP = 2'd3;

    localparam logic [11:0] SEC_LAST  = 12'd3599;
    localparam logic [8:0]  M300_LAST = 9'd299;
    localparam logic [5:0]  M60_LAST  = 6'd59;
    localparam logic [2:0]  M5_LAST   = 3'd4;

    localparam logic [49:0] MS_STEP = 50'd1000;
    localparam logic [49:0] MS_LATE = 50'd1500;

    typedef struct packed {
        logic [31:0] calls;
        logic [31:0] total;
        logic [31:0] max;
    } t_rec;

    function automatic t_rec rec_merge(input t_rec a, input t_rec b);
        t_rec r;
        r.calls = a.calls + b.calls;
        r.total = a.total + b.total;
        r.max   = (a.max > b.max) ? a.max : b.max;
        return r;
    endfunction

    function automatic logic [31:0] win_limit(input logic [1:0] w);
        logic [31:0] r;
        unique case (w)
            2'd0:    r = 32'd5000;
            2'd1:    r = 32'd60000;
            2'd2:    r = 32'd300000;
            default: r = 32'd3600000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/cascaded_window_timing_stats_top.sv =====
// Top level of the windowed timing statistics block: sequencer, time keeping and output stage.
// Depends on cwts_pkg, cwts_ram and cwts_div.
`default_nettype none
// A sample updates its event and source records, a clear zeroes all records of one source,
// and a read may wait for the 32-step divider for the average. A time check that ends a
// five-second window walks all SOURCES*(EVENTS+1) record blocks through the single record
// memory port pair. After reset a clearing pass zeroes all SOURCES*(EVENTS+1)*8 memory words
// before the first transfer is accepted. A read result waits in an output register, and the
// next transfer is accepted while it waits.
module cascaded_window_timing_stats_top #(
    parameter int unsigned SOURCES = 16,
    parameter int unsigned EVENTS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // source, event_req, duration_us, now_ms, window, per_event, zero padding
    input  wire logic [95:0]  i_s_tdata,
    // mode
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // calls, total_us, max_us, avg_us, has_data, zero padding
    output logic [135:0]      o_m_tdata
);
    import cwts_pkg::*;

    localparam int unsigned NEV   = SOURCES * EVENTS;
    localparam int unsigned NBLK  = SOURCES * (EVENTS + 1);
    localparam int unsigned BW    = $clog2(NBLK);
    localparam int unsigned AW    = BW + 3;
    localparam int unsigned DEPTH = NBLK * 8;
    localparam int unsigned EC_W  = $clog2(EVENTS + 1);
    localparam logic [BW-1:0]   EV_B     = BW'(EVENTS);
    localparam logic [BW-1:0]   NEV_B    = BW'(NEV);
    localparam logic [BW-1:0]   BLK_LAST = BW'(NBLK - 1);
    localparam logic [AW-1:0]   ADR_LAST = AW'(DEPTH - 1);
    localparam logic [EC_W-1:0] EC_LAST  = EC_W'(EVENTS);

    typedef enum logic [16:0] {
        ST_CLR  = 17'h00001,
        ST_IDLE = 17'h00002,
        ST_SMP0 = 17'h00004,
        ST_SMP1 = 17'h00008,
        ST_SMP2 = 17'h00010,
        ST_TC0  = 17'h00020,
        ST_TC1  = 17'h00040,
        ST_PW0  = 17'h00080,
        ST_PW1  = 17'h00100,
        ST_PW2  = 17'h00200,
        ST_PW3  = 17'h00400,
        ST_PW4  = 17'h00800,
        ST_PW5  = 17'h01000,
        ST_RD0  = 17'h02000,
        ST_RD1  = 17'h04000,
        ST_RD2  = 17'h08000,
        ST_CS   = 17'h10000
    } t_state;

    t_state r_state;

    logic [3:0]  r_src;
    logic [3:0]  r_ev;
    logic [31:0] r_dur;
    logic [47:0] r_now;
    logic [1:0]  r_win;
    logic        r_pe;

    logic [47:0] r_last_ms;
    logic [11:0] r_sec;
    logic [8:0]  r_m300;
    logic [5:0]  r_m60;
    logic [2:0]  r_m5;
    logic [3:0]  r_flags;

    logic [BW-1:0]   r_blk;
    logic [1:0]      r_w;
    logic [AW-1:0]   r_clr;
    logic [EC_W-1:0] r_e;
    logic [2:0]      r_k;
    t_rec            r_prev;
    t_rec            r_acc;
    t_rec            r_rd;

    logic          r_out_vld;
    logic [31:0]   r_o_calls;
    logic [31:0]   r_o_total;
    logic [31:0]   r_o_max;
    logic [31:0]   r_o_avg;
    logic          r_o_has;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_rec          ram_wdata;
    t_rec          ram_rdata;

    logic          div_start;
    logic          div_busy;
    logic [31:0]   div_quot;

    logic          src_ok;
    logic          ev_ok;
    logic [BW-1:0] blk_ev;
    logic [BW-1:0] blk_src;
    logic [BW-1:0] blk_cs;
    logic [BW-1:0] blk_rd;
    logic [49:0]   n_diff;
    logic [49:0]   n_cand;
    logic [49:0]   n_late;
    logic [11:0]   n_sec;
    logic [8:0]    n_m300;
    logic [5:0]    n_m60;
    logic [2:0]    n_m5;
    logic          rd_ok;
    logic          out_load;

    assign src_ok  = 32'(r_src) < SOURCES;
    assign ev_ok   = 32'(r_ev) < EVENTS;
    assign blk_ev  = BW'(BW'(r_src) * EV_B + BW'(r_ev));
    assign blk_src = BW'(NEV_B + BW'(r_src));
    assign blk_cs  = (r_e == EC_LAST) ? blk_src : BW'(BW'(r_src) * EV_B + BW'(r_e));
    assign blk_rd  = r_pe ? blk_ev : blk_src;
    assign rd_ok   = src_ok && (!r_pe || ev_ok);

    assign n_diff = {2'b0, r_now} - {2'b0, r_last_ms};
    assign n_cand = {2'b0, r_last_ms} + MS_STEP;
    assign n_late = {2'b0, r_now} - MS_LATE;
    assign n_sec  = (r_sec == SEC_LAST) ? '0 : r_sec + 12'd1;
    assign n_m300 = (r_m300 == M300_LAST) ? '0 : r_m300 + 9'd1;
    assign n_m60  = (r_m60 == M60_LAST) ? '0 : r_m60 + 6'd1;
    assign n_m5   = (r_m5 == M5_LAST) ? '0 : r_m5 + 3'd1;

    assign out_load = (r_state == ST_RD2) && !div_busy && (!r_out_vld || i_m_tready);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        div_start = 1'b0;
        unique case (r_state)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            ST_SMP0: begin
                ram_raddr = {blk_ev, 2'd0, SLOT_ACC};
            end
            ST_SMP1: begin
                ram_we    = 1'b1;
                ram_waddr = {blk_ev, 2'd0, SLOT_ACC};
                ram_wdata = rec_merge(ram_rdata, '{calls: 32'd1, total: r_dur, max: r_dur});
                ram_raddr = {blk_src, 2'd0, SLOT_ACC};
            end
            ST_SMP2: begin
                ram_we    = 1'b1;
                ram_waddr = {blk_src, 2'd0, SLOT_ACC};
                ram_wdata = rec_merge(ram_rdata, '{calls: 32'd0, total: r_dur, max: 32'd0});
            end
            ST_PW0: begin
                ram_raddr = {r_blk, r_w, SLOT_PREV};
            end
            ST_PW1: begin
                ram_raddr = {r_blk, r_w, SLOT_ACC};
            end
            ST_PW2: begin
                ram_raddr = {r_blk, r_w + 2'd1, SLOT_ACC};
            end
            ST_PW3: begin
                ram_we    = 1'b1;
                ram_waddr = {r_blk, r_w + 2'd1, SLOT_ACC};
                ram_wdata = rec_merge(ram_rdata, r_prev);
            end
            ST_PW4: begin
                ram_we    = 1'b1;
                ram_waddr = {r_blk, r_w, SLOT_PREV};
                ram_wdata = r_acc;
            end
            ST_PW5: begin
                ram_we    = 1'b1;
                ram_waddr = {r_blk, r_w, SLOT_ACC};
            end
            ST_RD0: begin
                ram_raddr = {blk_rd, r_win, SLOT_PREV};
            end
            ST_RD1: begin
                div_start = rd_ok && r_pe && (ram_rdata.calls != 32'd0);
            end
            ST_CS: begin
                ram_we    = src_ok;
                ram_waddr = {blk_cs, r_k};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr     <= '0;
            r_last_ms <= '0;
            r_sec     <= '0;
            r_m300    <= '0;
            r_m60     <= '0;
            r_m5      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == ADR_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_src  <= i_s_tdata[3:0];
                        r_ev   <= i_s_tdata[7:4];
                        r_dur  <= i_s_tdata[39:8];
                        r_now  <= i_s_tdata[87:40];
                        r_win  <= i_s_tdata[89:88];
                        r_pe   <= i_s_tdata[90];
                        r_e    <= '0;
                        r_k    <= '0;
                        unique case (i_s_tuser)
                            MODE_SAMPLE: r_state <= ST_SMP0;
                            MODE_TIME:   r_state <= ST_TC0;
                            MODE_READ:   r_state <= ST_RD0;
                            default:     r_state <= ST_CS;
                        endcase
                    end
                end
                ST_SMP0: begin
                    r_state <= (src_ok && ev_ok) ? ST_SMP1 : ST_IDLE;
                end
                ST_SMP1: begin
                    r_state <= ST_SMP2;
                end
                ST_SMP2: begin
                    r_state <= ST_IDLE;
                end
                ST_TC0: begin
                    r_state <= ($signed(n_diff) >= $signed(MS_STEP)) ? ST_TC1 : ST_IDLE;
                end
                ST_TC1: begin
                    r_last_ms <= ($signed(n_late) > $signed(n_cand)) ? n_late[47:0] : n_cand[47:0];
                    r_sec     <= n_sec;
                    r_m300    <= n_m300;
                    r_m60     <= n_m60;
                    r_m5      <= n_m5;
                    r_flags   <= {n_sec == '0, n_m300 == '0, n_m60 == '0, n_m5 == '0};
                    r_blk     <= '0;
                    r_w       <= '0;
                    r_state   <= (n_m5 == '0) ? ST_PW0 : ST_IDLE;
                end
                ST_PW0: begin
                    if (r_flags[r_w]) begin
                        r_state <= ST_PW1;
                    end else if (r_w != WIN_TOP) begin
                        r_w <= r_w + 2'd1;
                    end else if (r_blk == BLK_LAST) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_blk <= r_blk + BW'(1);
                        r_w   <= '0;
                    end
                end
                ST_PW1: begin
                    r_prev  <= ram_rdata;
                    r_state <= ST_PW2;
                end
                ST_PW2: begin
                    r_acc   <= ram_rdata;
                    r_state <= (r_w == WIN_TOP) ? ST_PW4 : ST_PW3;
                end
                ST_PW3: begin
                    r_state <= ST_PW4;
                end
                ST_PW4: begin
                    r_state <= ST_PW5;
                end
                ST_PW5: begin
                    r_state <= ST_PW0;
                    if (r_w != WIN_TOP) begin
                        r_w <= r_w + 2'd1;
                    end else if (r_blk == BLK_LAST) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_blk <= r_blk + BW'(1);
                        r_w   <= '0;
                    end
                end
                ST_RD0: begin
                    r_state <= ST_RD1;
                end
                ST_RD1: begin
                    r_rd.calls <= (rd_ok && r_pe) ? ram_rdata.calls : '0;
                    r_rd.total <= rd_ok ? ram_rdata.total : '0;
                    r_rd.max   <= (rd_ok && r_pe) ? ram_rdata.max : '0;
                    r_state    <= ST_RD2;
                end
                ST_RD2: begin
                    if (out_load) begin
                        r_o_calls <= r_rd.calls;
                        r_o_total <= r_rd.total;
                        r_o_max   <= r_rd.max;
                        r_o_avg   <= (r_rd.calls != '0) ? div_quot : '0;
                        r_o_has   <= r_rd.total > win_limit(r_win);
                        r_state   <= ST_IDLE;
                    end
                end
                ST_CS: begin
                    if (!src_ok) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'd7) begin
                            r_e <= r_e + EC_W'(1);
                            if (r_e == EC_LAST) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    cwts_ram #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cwts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (ram_rdata.total),
        .i_den   (ram_rdata.calls),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'd0, r_o_has, r_o_avg, r_o_max, r_o_total, r_o_calls};

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("Block stayed ready after accepting a transfer.");

    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == ST_RD2))
        else $error("Result appeared outside the read sequence.");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("Divider started while busy.");

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sec <= SEC_LAST) && (r_m5 <= M5_LAST) && (r_m60 <= M60_LAST))
        else $error("Second counters out of range.");

endmodule
`default_nettype wire

// ===== hdl/cwts_ram.sv =====
// Record memory with one write port and one registered read port.
// Depends on cwts_pkg for the record type.
`default_nettype none
module cwts_ram #(
    parameter int unsigned AW = 11,
    parameter int unsigned DEPTH = 2176
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  cwts_pkg::t_rec     i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output cwts_pkg::t_rec     o_rdata
);
    import cwts_pkg::*;

    t_rec r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/cwts_div.sv =====
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// Depends on nothing outside this file.
`default_nettype none
module cwts_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic [31:0]      o_quot
);
    logic [31:0] r_rem;
    logic [31:0] r_quot;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_shift;
    logic [32:0] n_diff;

    assign n_shift = {r_rem, r_quot[31]};
    assign n_diff  = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!n_diff[32]) begin
                r_rem  <= n_diff[31:0];
                r_quot <= {r_quot[30:0], 1'b1};
            end else begin
                r_rem  <= n_shift[31:0];
                r_quot <= {r_quot[30:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for cascaded_window_timing_stats_top: a queue-fed stream driver,
// a result monitor and an in-bench model of the windowed statistics. Depends on cwts_pkg.
`default_nettype none
module tb;
    import cwts_pkg::*;

    localparam int unsigned NSRC = 16;
    localparam int unsigned NEV = 16;
    localparam int unsigned EV_SLOTS = NSRC * NEV * 8;
    localparam int unsigned SRC_SLOTS = NSRC * 8;
    localparam longint unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  source;
        logic [3:0]  event_req;
        logic [31:0] duration_us;
        logic [47:0] now_ms;
        logic [1:0]  window;
        logic        per_event;
    } t_req;

    typedef struct packed {
        logic [31:0] calls;
        logic [31:0] sum_us;
        logic [31:0] max_us;
        logic [31:0] avg_us;
        logic        has_data;
    } t_stat;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [95:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [135:0] m_tdata;

    cascaded_window_timing_stats_top #(.SOURCES(NSRC), .EVENTS(NEV)) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata(m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] ev_calls [EV_SLOTS];
    logic [31:0] ev_total [EV_SLOTS];
    logic [31:0] ev_max [EV_SLOTS];
    logic [31:0] src_total [SRC_SLOTS];
    logic [47:0] last_sec_ms;
    logic [11:0] sec_count;

    // Both queues take new entries at the front and hand them out from the back.
    t_req  pending_reqs[$];
    t_stat expected_stats[$];
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    fail_count = 0;
    bit    stimulus_done = 0;
    longint unsigned cycle_count = 0;

    function automatic int ev_idx(int s, int e, int w, int slot);
        return ((s * NEV + e) * 8) + w * 2 + slot;
    endfunction

    function automatic void pulse_windows(logic [3:0] flags);
        int up;
        int a;
        for (int s = 0; s < NSRC; s++) begin
            for (int w = 0; w < NWIN; w++) begin
                if (flags[w]) begin
                    a = s * 8 + w * 2;
                    if (w < NWIN - 1)
                        src_total[a + 2] += src_total[a + 1];
                    src_total[a + 1] = src_total[a];
                    src_total[a] = '0;
                end
            end
            for (int e = 0; e < NEV; e++) begin
                for (int w = 0; w < NWIN; w++) begin
                    if (flags[w]) begin
                        a = ev_idx(s, e, w, 0);
                        if (w < NWIN - 1) begin
                            up = a + 2;
                            ev_calls[up] += ev_calls[a + 1];
                            ev_total[up] += ev_total[a + 1];
                            if (ev_max[a + 1] > ev_max[up])
                                ev_max[up] = ev_max[a + 1];
                        end
                        ev_calls[a + 1] = ev_calls[a];
                        ev_total[a + 1] = ev_total[a];
                        ev_max[a + 1] = ev_max[a];
                        ev_calls[a] = '0;
                        ev_total[a] = '0;
                        ev_max[a] = '0;
                    end
                end
            end
        end
    endfunction

    function automatic void stats_apply(t_req r);
        t_stat res;
        logic signed [48:0] diff;
        logic [48:0] cand;
        logic [48:0] late;
        logic [3:0] flags;
        int i;
        int b;
        case (r.mode)
            MODE_SAMPLE: begin
                b = r.source * 8;
                src_total[b] += r.duration_us;
                i = ev_idx(r.source, r.event_req, 0, 0);
                ev_calls[i] += 1;
                ev_total[i] += r.duration_us;
                if (r.duration_us > ev_max[i])
                    ev_max[i] = r.duration_us;
            end
            MODE_TIME: begin
                diff = $signed({1'b0, r.now_ms}) - $signed({1'b0, last_sec_ms});
                if (diff >= 1000) begin
                    cand = {1'b0, last_sec_ms} + 49'd1000;
                    late = {1'b0, r.now_ms} - 49'd1500;
                    if ($signed(late) > $signed(cand))
                        cand = late;
                    last_sec_ms = cand[47:0];
                    sec_count = (sec_count == 12'd3599) ? 12'd0 : sec_count + 12'd1;
                    flags[0] = (sec_count % 5) == 0;
                    flags[1] = (sec_count % 60) == 0;
                    flags[2] = (sec_count % 300) == 0;
                    flags[3] = sec_count == 0;
                    pulse_windows(flags);
                end
            end
            MODE_READ: begin
                res = '0;
                if (r.per_event == 1'b0) begin
                    res.sum_us = src_total[r.source * 8 + r.window * 2 + 1];
                end else begin
                    i = ev_idx(r.source, r.event_req, r.window, 1);
                    res.calls = ev_calls[i];
                    res.sum_us = ev_total[i];
                    res.max_us = ev_max[i];
                end
                if (res.calls != 0)
                    res.avg_us = res.sum_us / res.calls;
                res.has_data = res.sum_us > win_limit(r.window);
                expected_stats.push_front(res);
            end
            default: begin
                for (int k = 0; k < 8; k++)
                    src_total[r.source * 8 + k] = '0;
                for (int k = 0; k < NEV * 8; k++) begin
                    ev_calls[r.source * NEV * 8 + k] = '0;
                    ev_total[r.source * NEV * 8 + k] = '0;
                    ev_max[r.source * NEV * 8 + k] = '0;
                end
            end
        endcase
    endfunction

    function automatic t_req req_from_bus(logic [1:0] u, logic [95:0] d);
        t_req r;
        r.mode = u;
        r.source = d[3:0];
        r.event_req = d[7:4];
        r.duration_us = d[39:8];
        r.now_ms = d[87:40];
        r.window = d[89:88];
        r.per_event = d[90];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                stats_apply(req_from_bus(s_tuser, s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_req r;
                    r = pending_reqs.pop_back();
                    s_tvalid <= 1'b1;
                    s_tuser <= r.mode;
                    s_tdata <= {5'd0, r.per_event, r.window, r.now_ms, r.duration_us,
                                r.event_req, r.source};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_stat got;
        t_stat want;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (m_tvalid && m_tready) begin
                got.calls = m_tdata[31:0];
                got.sum_us = m_tdata[63:32];
                got.max_us = m_tdata[95:64];
                got.avg_us = m_tdata[127:96];
                got.has_data = m_tdata[128];
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_stats.pop_back();
                    if (got.calls !== want.calls)
                        $display("%0t: calls expected %h actual %h", $time, want.calls,
                                 got.calls);
                    if (got.sum_us !== want.sum_us)
                        $display("%0t: sum_us expected %h actual %h", $time,
                                 want.sum_us, got.sum_us);
                    if (got.max_us !== want.max_us)
                        $display("%0t: max_us expected %h actual %h", $time, want.max_us,
                                 got.max_us);
                    if (got.avg_us !== want.avg_us)
                        $display("%0t: avg_us expected %h actual %h", $time, want.avg_us,
                                 got.avg_us);
                    if (got.has_data !== want.has_data)
                        $display("%0t: has_data expected %h actual %h", $time,
                                 want.has_data, got.has_data);
                    if (got !== want)
                        fail_count++;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("cascaded_window_timing_stats_top regression: fail");
                $finish;
            end
        end
    end

    function automatic t_req rand_req(int unsigned mode);
        t_req r;
        r.mode = mode[1:0];
        r.source = 4'($urandom_range(3));
        if ($urandom_range(9) == 0)
            r.source = 4'($urandom);
        r.event_req = 4'($urandom_range(3));
        if ($urandom_range(9) == 0)
            r.event_req = 4'($urandom);
        case ($urandom_range(3))
            0: r.duration_us = $urandom;
            1: r.duration_us = $urandom_range(3000);
            2: r.duration_us = 32'hFFFF_FFFF - $urandom_range(3);
            default: r.duration_us = $urandom_range(200000);
        endcase
        r.now_ms = 48'({$urandom, $urandom});
        r.window = 2'($urandom);
        r.per_event = 1'($urandom);
        return r;
    endfunction

    function automatic t_req time_req(logic [47:0] now);
        t_req r;
        r = '0;
        r.mode = MODE_TIME;
        r.now_ms = now;
        return r;
    endfunction

    task automatic run_phase(int idle, int stall, int count);
        t_req r;
        logic [47:0] now;
        int unsigned pick;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        now = last_sec_ms + 48'd1000;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                r = rand_req(MODE_SAMPLE);
            end else if (pick < 65) begin
                now = now + $urandom_range(900, 2500);
                r = time_req(now);
                if ($urandom_range(19) == 0)
                    r.now_ms = $urandom_range(1, 999) + r.now_ms - 48'd1000;
            end else if (pick < 95) begin
                r = rand_req(MODE_READ);
            end else begin
                r = rand_req(MODE_CLEAR);
            end
            pending_reqs.push_front(r);
        end
        wait (pending_reqs.size() == 0);
    endtask

    initial begin
        t_req r;
        for (int k = 0; k < EV_SLOTS; k++) begin
            ev_calls[k] = '0;
            ev_total[k] = '0;
            ev_max[k] = '0;
        end
        for (int k = 0; k < SRC_SLOTS; k++)
            src_total[k] = '0;
        last_sec_ms = '0;
        sec_count = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        r = rand_req(MODE_SAMPLE);
        r.source = 4'd15;
        r.event_req = 4'd15;
        r.duration_us = 32'hFFFF_FFFF;
        pending_reqs.push_front(r);
        r.duration_us = 32'd7;
        pending_reqs.push_front(r);
        r.source = 4'd0;
        r.event_req = 4'd0;
        r.duration_us = 32'd6000;
        pending_reqs.push_front(r);
        r.duration_us = 32'd0;
        pending_reqs.push_front(r);
        pending_reqs.push_front(time_req(48'd999));
        pending_reqs.push_front(time_req(48'd100_000));
        for (int k = 0; k < 6; k++)
            pending_reqs.push_front(time_req(48'd100_000 + 48'(1000 * (k + 1))));
        for (int w = 0; w < NWIN; w++) begin
            r = rand_req(MODE_READ);
            r.window = 2'(w);
            r.source = (w == 3) ? 4'd15 : 4'd0;
            r.event_req = r.source;
            r.per_event = w[0];
            pending_reqs.push_front(r);
        end
        r = rand_req(MODE_CLEAR);
        r.source = 4'd15;
        pending_reqs.push_front(r);
        r = rand_req(MODE_READ);
        r.source = 4'd15;
        r.event_req = 4'd15;
        r.per_event = 1'b1;
        pending_reqs.push_front(r);
        wait (pending_reqs.size() == 0);

        run_phase(0, 0, 250);
        run_phase(59, 0, 250);
        run_phase(0, 59, 250);
        run_phase(15, 15, 250);

        wait (expected_stats.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("cascaded_window_timing_stats_top regression: pass");
        else
            $display("cascaded_window_timing_stats_top regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
